// ===== sv/b2r_pkg.sv =====
package b2r_pkg;

   localparam int DISPLAY_WIDTH_DEF = 240;
   localparam int DISPLAY_HEIGHT_DEF = 320;
   localparam int MAX_IMAGE_WIDTH_DEF = 4096;

   localparam logic [16:0] SCALE_ONE = 17'h10000;
   localparam logic [15:0] ROUND_HALF = 16'h8000;
   localparam logic [15:0] GREEN_MASK = 16'h07E0;
   localparam logic [15:0] RED_MASK = 16'hF800;

   localparam logic [12:0] IMAGE_WIDTH_RESET = 13'd240;
   localparam logic [15:0] DATA_OFFSET_RESET = 16'd54;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH = 2'd0,
      REG_DATA_OFFSET = 2'd1,
      REG_X_SCALE = 2'd2,
      REG_Y_SCALE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [16:0] x_scale;
      logic [16:0] y_scale;
   } scale_type;

   typedef struct packed {
      logic [11:0] col;
      logic [15:0] row;
      logic [15:0] color;
   } pixel_type;

endpackage

// ===== sv/b2r_if.sv =====
interface b2r_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic file_start;
   modport source(output valid, data_byte, file_start, input ready);
   modport sink(input valid, data_byte, file_start, output ready);
endinterface

interface b2r_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] screen_col;
   logic [8:0] screen_row;
   logic [15:0] pixel_color;
   modport source(output valid, screen_col, screen_row, pixel_color, input ready);
   modport sink(input valid, screen_col, screen_row, pixel_color, output ready);
endinterface

interface b2r_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [16:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/b2r_csr.sv =====
module b2r_csr #(
   parameter int MAX_IMAGE_WIDTH = b2r_pkg::MAX_IMAGE_WIDTH_DEF,
   localparam int STRIDE_MAX = ((3 * MAX_IMAGE_WIDTH + 3) / 4) * 4,
   localparam int RBC_W = $clog2(STRIDE_MAX + 1)
) (
   input  logic clock,
   input  logic reset,
   b2r_csr_if.sink csr,
   output logic [RBC_W-1:0] row_bytes,
   output logic [RBC_W-1:0] stride,
   output logic [15:0] data_offset,
   output b2r_pkg::scale_type scale
);

   logic [RBC_W-1:0] row_bytes_ff, row_bytes_in;
   logic [RBC_W-1:0] stride_ff, stride_in;
   logic [15:0] data_offset_ff, data_offset_in;
   b2r_pkg::scale_type scale_ff, scale_in;
   logic [12:0] width_raw;
   int width_clamped;
   logic [16:0] scale_clamped;

   assign csr.ready = 1'b1;

   always_comb begin
      width_raw = csr.data[12:0];
      if (width_raw == 13'd0) begin
         width_clamped = 1;
      end else if (int'(width_raw) > MAX_IMAGE_WIDTH) begin
         width_clamped = MAX_IMAGE_WIDTH;
      end else begin
         width_clamped = int'(width_raw);
      end
      scale_clamped = (csr.data > b2r_pkg::SCALE_ONE) ? b2r_pkg::SCALE_ONE : csr.data;
      row_bytes_in = row_bytes_ff;
      stride_in = stride_ff;
      data_offset_in = data_offset_ff;
      scale_in = scale_ff;
      if (csr.valid) begin
         case (b2r_pkg::csr_index_type'(csr.index))
            b2r_pkg::REG_IMAGE_WIDTH: begin
               row_bytes_in = RBC_W'(3 * width_clamped);
               stride_in = RBC_W'(((3 * width_clamped + 3) / 4) * 4);
            end
            b2r_pkg::REG_DATA_OFFSET: data_offset_in = csr.data[15:0];
            b2r_pkg::REG_X_SCALE: scale_in.x_scale = scale_clamped;
            b2r_pkg::REG_Y_SCALE: scale_in.y_scale = scale_clamped;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= RBC_W'(3 * int'(b2r_pkg::IMAGE_WIDTH_RESET));
         stride_ff <= RBC_W'(((3 * int'(b2r_pkg::IMAGE_WIDTH_RESET) + 3) / 4) * 4);
         data_offset_ff <= b2r_pkg::DATA_OFFSET_RESET;
         scale_ff.x_scale <= b2r_pkg::SCALE_ONE;
         scale_ff.y_scale <= b2r_pkg::SCALE_ONE;
      end else begin
         row_bytes_ff <= row_bytes_in;
         stride_ff <= stride_in;
         data_offset_ff <= data_offset_in;
         scale_ff <= scale_in;
      end
   end

   assign row_bytes = row_bytes_ff;
   assign stride = stride_ff;
   assign data_offset = data_offset_ff;
   assign scale = scale_ff;

endmodule

// ===== sv/b2r_parse.sv =====
module b2r_parse #(
   parameter int MAX_IMAGE_WIDTH = b2r_pkg::MAX_IMAGE_WIDTH_DEF,
   localparam int STRIDE_MAX = ((3 * MAX_IMAGE_WIDTH + 3) / 4) * 4,
   localparam int RBC_W = $clog2(STRIDE_MAX + 1)
) (
   input  logic clock,
   input  logic reset,
   b2r_req_if.sink req,
   input  logic [RBC_W-1:0] row_bytes,
   input  logic [RBC_W-1:0] stride,
   input  logic [15:0] data_offset,
   output logic pix_valid,
   output b2r_pkg::pixel_type pix,
   input  logic pix_ready
);

   typedef enum logic [1:0] {
      PHASE_BLUE = 2'd0,
      PHASE_GREEN = 2'd1,
      PHASE_RED = 2'd2
   } phase_type;

   logic [15:0] fp_ff, fp_in, fp;
   logic [1:0] phase_ff, phase_in, phase;
   logic [15:0] part_ff, part_in, part;
   logic [11:0] col_ff, col_in, col;
   logic [15:0] row_ff, row_in, row;
   logic [RBC_W-1:0] rbc_ff, rbc_in, rbc, rbc_next;
   logic pix_valid_ff, pix_valid_in;
   b2r_pkg::pixel_type pix_ff, pix_in;
   logic accept, emit;

   assign req.ready = !pix_valid_ff || pix_ready;
   assign accept = req.valid && req.ready;

   always_comb begin
      fp = req.file_start ? 16'd0 : fp_ff;
      phase = req.file_start ? 2'd0 : phase_ff;
      part = req.file_start ? 16'd0 : part_ff;
      col = req.file_start ? 12'd0 : col_ff;
      row = req.file_start ? 16'd0 : row_ff;
      rbc = req.file_start ? '0 : rbc_ff;
      fp_in = fp;
      phase_in = phase;
      part_in = part;
      col_in = col;
      row_in = row;
      rbc_in = rbc;
      rbc_next = rbc + RBC_W'(1);
      emit = 1'b0;
      pix_in.col = col;
      pix_in.row = row;
      pix_in.color = part | ({req.data_byte, 8'd0} & b2r_pkg::RED_MASK);
      if (fp < data_offset) begin
         fp_in = fp + 16'd1;
      end else begin
         if (rbc < row_bytes) begin
            case (phase_type'(phase))
               PHASE_BLUE: begin
                  part_in = {11'd0, req.data_byte[7:3]};
                  phase_in = PHASE_GREEN;
               end
               PHASE_GREEN: begin
                  part_in = part | ({5'd0, req.data_byte, 3'd0} & b2r_pkg::GREEN_MASK);
                  phase_in = PHASE_RED;
               end
               default: begin
                  emit = 1'b1;
                  part_in = 16'd0;
                  phase_in = PHASE_BLUE;
                  col_in = col + 12'd1;
               end
            endcase
         end
         if (rbc_next >= stride) begin
            rbc_in = '0;
            phase_in = PHASE_BLUE;
            part_in = 16'd0;
            col_in = 12'd0;
            if (row != 16'hFFFF) begin
               row_in = row + 16'd1;
            end
         end else begin
            rbc_in = rbc_next;
         end
      end
      if (accept) begin
         pix_valid_in = emit;
      end else if (pix_ready) begin
         pix_valid_in = 1'b0;
      end else begin
         pix_valid_in = pix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff <= 16'd0;
         phase_ff <= PHASE_BLUE;
         part_ff <= 16'd0;
         col_ff <= 12'd0;
         row_ff <= 16'd0;
         rbc_ff <= '0;
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         if (accept) begin
            fp_ff <= fp_in;
            phase_ff <= phase_in;
            part_ff <= part_in;
            col_ff <= col_in;
            row_ff <= row_in;
            rbc_ff <= rbc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = pix_valid_ff;
   assign pix = pix_ff;

endmodule

// ===== sv/b2r_scale.sv =====
module b2r_scale #(
   parameter int DISPLAY_WIDTH = b2r_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = b2r_pkg::DISPLAY_HEIGHT_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic pix_valid,
   input  b2r_pkg::pixel_type pix,
   output logic pix_ready,
   input  b2r_pkg::scale_type scale,
   b2r_rsp_if.source rsp
);

   logic [29:0] col_sum;
   logic [33:0] row_sum;
   logic [13:0] col_scaled;
   logic [17:0] row_scaled;
   logic visible;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] col_ff;
   logic [8:0] row_ff;
   logic [15:0] color_ff;

   assign pix_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      col_sum = 30'(pix.col) * 30'(scale.x_scale) + 30'(b2r_pkg::ROUND_HALF);
      row_sum = 34'(pix.row) * 34'(scale.y_scale) + 34'(b2r_pkg::ROUND_HALF);
      col_scaled = col_sum[29:16];
      row_scaled = row_sum[33:16];
      visible = (32'(row_scaled) < 32'(DISPLAY_HEIGHT)) && (32'(col_scaled) < 32'(DISPLAY_WIDTH));
      if (pix_ready) begin
         rsp_valid_in = pix_valid && visible;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_ready && pix_valid) begin
         col_ff <= col_scaled[7:0];
         row_ff <= row_scaled[8:0];
         color_ff <= pix.color;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.screen_col = col_ff;
   assign rsp.screen_row = row_ff;
   assign rsp.pixel_color = color_ff;

endmodule

// ===== sv/bmp24_to_rgb565_scaled_writer_unit.sv =====
// Channel  Role    Payload                                    Moves a word when
// req      sink    data_byte, file_start                      valid && ready
// rsp      source  screen_col, screen_row, pixel_color        valid && ready
// csr      sink    index (2 bits), data (17 bits)             valid && ready
//
// One file byte is taken every cycle while req is ready; a red byte can emit a pixel write.
// The byte counters update on acceptance, then one scaling multiply per axis sits
// between the pixel register and the output register.
// Reset is synchronous; it clears the counters and restores the register defaults.
// A stalled rsp holds its word; req stops only when both pixel stages are full.
// The csr port is always ready.
module bmp24_to_rgb565_scaled_writer_unit #(
   parameter int DISPLAY_WIDTH = b2r_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = b2r_pkg::DISPLAY_HEIGHT_DEF,
   parameter int MAX_IMAGE_WIDTH = b2r_pkg::MAX_IMAGE_WIDTH_DEF,
   localparam int STRIDE_MAX = ((3 * MAX_IMAGE_WIDTH + 3) / 4) * 4,
   localparam int RBC_W = $clog2(STRIDE_MAX + 1)
) (
   input  logic clock,
   input  logic reset,
   b2r_req_if.sink req,
   b2r_rsp_if.source rsp,
   b2r_csr_if.sink csr
);

   logic [RBC_W-1:0] row_bytes;
   logic [RBC_W-1:0] stride;
   logic [15:0] data_offset;
   b2r_pkg::scale_type scale;
   logic pix_valid;
   logic pix_ready;
   b2r_pkg::pixel_type pix;

   b2r_csr #(
      .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .csr(csr),
      .row_bytes(row_bytes),
      .stride(stride),
      .data_offset(data_offset),
      .scale(scale)
   );

   b2r_parse #(
      .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .req(req),
      .row_bytes(row_bytes),
      .stride(stride),
      .data_offset(data_offset),
      .pix_valid(pix_valid),
      .pix(pix),
      .pix_ready(pix_ready)
   );

   b2r_scale #(
      .DISPLAY_WIDTH(DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
   ) u_scale (
      .clock(clock),
      .reset(reset),
      .pix_valid(pix_valid),
      .pix(pix),
      .pix_ready(pix_ready),
      .scale(scale),
      .rsp(rsp)
   );

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 1000;
   localparam int ROW_LIMIT = 65535;
   localparam logic [8:0] PACKING_SEQ [27] = '{
      9'h111, 9'h022, 9'h033,
      9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h05A, 9'h0A5,
      9'h007, 9'h003, 9'h007, 9'h0F8, 9'h0FC, 9'h0F8, 9'h0C3, 9'h03C,
      9'h012, 9'h034, 9'h156, 9'h078, 9'h09A, 9'h00F, 9'h0F0, 9'h081
   };

   typedef enum int {PH_BLUE, PH_GREEN, PH_RED} color_phase_type;

   typedef struct packed {
      logic [7:0] col;
      logic [8:0] row;
      logic [15:0] color;
   } display_write_type;

   logic clock;
   logic reset;

   b2r_req_if req_bus();
   b2r_rsp_if rsp_bus();
   b2r_csr_if csr_bus();

   bmp24_to_rgb565_scaled_writer_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .csr(csr_bus)
   );

   logic [12:0] cfg_width;
   logic [15:0] cfg_offset;
   logic [16:0] cfg_x_scale;
   logic [16:0] cfg_y_scale;

   int unsigned file_pos;
   color_phase_type byte_phase;
   logic [15:0] partial_color;
   int unsigned col_idx;
   int unsigned row_idx;
   int unsigned row_count;

   display_write_type pending_writes[$];
   int errors = 0;
   int used_bytes = 0;
   int idle_cycles = 0;
   bit send_burst = 0;
   bit rsp_burst = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void clear_position();
      file_pos = 0;
      byte_phase = PH_BLUE;
      partial_color = '0;
      col_idx = 0;
      row_idx = 0;
      row_count = 0;
   endfunction

   // Advances the pixel state by one file byte and queues the display write it
   // causes. Returns 1 when the byte lies in the pixel data.
   function automatic bit convert_byte(input logic [7:0] b, input logic st);
      int unsigned w;
      int unsigned row_bytes;
      int unsigned stride;
      longint unsigned sx;
      longint unsigned sy;
      longint unsigned scol;
      longint unsigned srow;
      display_write_type wr;
      if (st)
         clear_position();
      if (file_pos < cfg_offset) begin
         file_pos++;
         return 1'b0;
      end
      w = cfg_width;
      if (w < 1)
         w = 1;
      if (w > b2r_pkg::MAX_IMAGE_WIDTH_DEF)
         w = b2r_pkg::MAX_IMAGE_WIDTH_DEF;
      row_bytes = 3 * w;
      stride = (row_bytes + 3) & ~32'd3;
      if (row_count < row_bytes) begin
         case (byte_phase)
            PH_BLUE: begin
               partial_color = {11'd0, b[7:3]};
               byte_phase = PH_GREEN;
            end
            PH_GREEN: begin
               partial_color = partial_color | ((16'(b) << 3) & b2r_pkg::GREEN_MASK);
               byte_phase = PH_RED;
            end
            default: begin
               sx = 64'((cfg_x_scale > b2r_pkg::SCALE_ONE) ? b2r_pkg::SCALE_ONE : cfg_x_scale);
               sy = 64'((cfg_y_scale > b2r_pkg::SCALE_ONE) ? b2r_pkg::SCALE_ONE : cfg_y_scale);
               scol = (col_idx * sx + b2r_pkg::ROUND_HALF) >> 16;
               srow = (row_idx * sy + b2r_pkg::ROUND_HALF) >> 16;
               if (srow < b2r_pkg::DISPLAY_HEIGHT_DEF && scol < b2r_pkg::DISPLAY_WIDTH_DEF) begin
                  wr.col = scol[7:0];
                  wr.row = srow[8:0];
                  wr.color = partial_color | ((16'(b) << 8) & b2r_pkg::RED_MASK);
                  pending_writes.push_back(wr);
               end
               partial_color = '0;
               byte_phase = PH_BLUE;
               col_idx = (col_idx + 1) & 32'hFFF;
            end
         endcase
      end
      row_count++;
      if (row_count >= stride) begin
         row_count = 0;
         byte_phase = PH_BLUE;
         partial_color = '0;
         col_idx = 0;
         if (row_idx < ROW_LIMIT)
            row_idx++;
      end
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic st);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.file_start <= st;
      do @(posedge clock); while (!req_bus.ready);
      if (convert_byte(b, st))
         used_bytes++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input b2r_pkg::csr_index_type idx, input logic [16:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         b2r_pkg::REG_IMAGE_WIDTH: cfg_width = value[12:0];
         b2r_pkg::REG_DATA_OFFSET: cfg_offset = value[15:0];
         b2r_pkg::REG_X_SCALE: cfg_x_scale = value;
         default: cfg_y_scale = value;
      endcase
   endtask

   task automatic load_setup(input logic [16:0] width, input logic [16:0] offset,
                             input logic [16:0] xs, input logic [16:0] ys);
      wait_drained();
      write_csr(b2r_pkg::REG_IMAGE_WIDTH, width);
      write_csr(b2r_pkg::REG_DATA_OFFSET, offset);
      write_csr(b2r_pkg::REG_X_SCALE, xs);
      write_csr(b2r_pkg::REG_Y_SCALE, ys);
   endtask

   task automatic send_file(input int count);
      send_byte(8'($urandom), 1'b1);
      repeat (count - 1) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic test_reset_defaults();
      send_file(54 + 12);
   endtask

   task automatic test_pixel_packing();
      load_setup(17'd2, 17'd3, b2r_pkg::SCALE_ONE, b2r_pkg::SCALE_ONE);
      foreach (PACKING_SEQ[i])
         send_byte(PACKING_SEQ[i][7:0], PACKING_SEQ[i][8]);
   endtask

   task automatic test_scaling();
      load_setup(17'd5, 17'd0, 17'd32768, 17'd43690);
      send_file(48);
      load_setup(17'd3, 17'd0, 17'd0, 17'd0);
      send_file(36);
      load_setup(17'd3, 17'd0, 17'h1FFFF, 17'h10001);
      send_file(36);
   endtask

   task automatic test_width_extremes();
      load_setup(17'd0, 17'd0, b2r_pkg::SCALE_ONE, b2r_pkg::SCALE_ONE);
      send_file(12);
      load_setup(17'h1FFFF, 17'd0, b2r_pkg::SCALE_ONE, b2r_pkg::SCALE_ONE);
      send_file(12);
      load_setup(17'd4096, 17'd0, b2r_pkg::SCALE_ONE, b2r_pkg::SCALE_ONE);
      send_file(12);
      load_setup(17'd1, 17'hFFFF, b2r_pkg::SCALE_ONE, b2r_pkg::SCALE_ONE);
      send_file(6);
   endtask

   task automatic test_width_change_mid_row();
      load_setup(17'd4, 17'd0, b2r_pkg::SCALE_ONE, b2r_pkg::SCALE_ONE);
      send_file(10);
      wait_drained();
      write_csr(b2r_pkg::REG_IMAGE_WIDTH, 17'd1);
      repeat (8) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic test_random_files();
      int goal;
      int len;
      logic [16:0] value;
      goal = used_bytes + 300;
      while (used_bytes < goal) begin
         send_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         wait_drained();
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 1)) begin
               case (b2r_pkg::csr_index_type'(i))
                  b2r_pkg::REG_IMAGE_WIDTH: begin
                     case ($urandom_range(0, 9))
                        0: value = 17'd0;
                        1: value = 17'($urandom_range(0, 17'h1FFFF));
                        2: value = 17'($urandom_range(7, 64));
                        default: value = 17'($urandom_range(1, 6));
                     endcase
                  end
                  b2r_pkg::REG_DATA_OFFSET: begin
                     case ($urandom_range(0, 9))
                        0: value = 17'($urandom_range(0, 17'h1FFFF));
                        1: value = 17'($urandom_range(7, 60));
                        default: value = 17'($urandom_range(0, 6));
                     endcase
                  end
                  default: begin
                     case ($urandom_range(0, 7))
                        0: value = 17'd0;
                        1: value = b2r_pkg::SCALE_ONE;
                        2: value = 17'($urandom_range(17'h10001, 17'h1FFFF));
                        3: value = 17'($urandom_range(0, 17'h1FFFF));
                        default: value = 17'($urandom_range(16384, 65536));
                     endcase
                  end
               endcase
               write_csr(b2r_pkg::csr_index_type'(i), value);
            end
         end
         if ($urandom_range(0, 7) != 0)
            send_byte(8'($urandom), 1'b1);
         len = $urandom_range(12, 72);
         repeat (len) send_byte(8'($urandom), ($urandom_range(0, 49) == 0));
      end
   endtask

   initial begin : rsp_sink
      int stall;
      display_write_type want;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected word col %0d row %0d color %h", $realtime,
                     rsp_bus.screen_col, rsp_bus.screen_row, rsp_bus.pixel_color);
            errors++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_bus.screen_col !== want.col) begin
               $display("%0t: screen_col expected %0d actual %0d", $realtime,
                        want.col, rsp_bus.screen_col);
               errors++;
            end
            if (rsp_bus.screen_row !== want.row) begin
               $display("%0t: screen_row expected %0d actual %0d", $realtime,
                        want.row, rsp_bus.screen_row);
               errors++;
            end
            if (rsp_bus.pixel_color !== want.color) begin
               $display("%0t: pixel_color expected %h actual %h", $realtime,
                        want.color, rsp_bus.pixel_color);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.file_start <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= b2r_pkg::REG_IMAGE_WIDTH;
      csr_bus.data <= '0;
      cfg_width = b2r_pkg::IMAGE_WIDTH_RESET;
      cfg_offset = b2r_pkg::DATA_OFFSET_RESET;
      cfg_x_scale = b2r_pkg::SCALE_ONE;
      cfg_y_scale = b2r_pkg::SCALE_ONE;
      clear_position();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_pixel_packing();
      test_scaling();
      test_width_extremes();
      test_width_change_mid_row();
      test_random_files();
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
sv/b2r_pkg.sv
sv/b2r_if.sv
sv/b2r_csr.sv
sv/b2r_parse.sv
sv/b2r_scale.sv
sv/bmp24_to_rgb565_scaled_writer_unit.sv
tb/testbench.sv
